// File: hw/rtl/iparp_pkg.sv
// Package for the IPv4/ARP/ICMP receive classifier.
// Holds verdict codes, register indexes, frame constants, the frame state struct and the ones' complement add.
// No dependencies.
package iparp_pkg;

    localparam int unsigned MAX_FRAME = 16384;
    localparam int unsigned CNT_W     = 16;

    localparam logic [0:0] REG_LOCAL_IP = 1'b0;
    localparam logic [0:0] REG_MASK     = 1'b1;

    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] SUM_OK     = 16'hffff;
    localparam logic [3:0]  IP_VERSION = 4'd4;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] ICMP_ECHO  = 8'd8;

    typedef enum logic [4:0] {
        V_SHORT      = 5'd0,
        V_OTHER_ETH  = 5'd1,
        V_ARP_BAD    = 5'd2,
        V_ARP_NOTOUR = 5'd3,
        V_ARP_LEARN  = 5'd4,
        V_ARP_REQ    = 5'd5,
        V_IP_INVALID = 5'd6,
        V_IP_CSUM    = 5'd7,
        V_IP_NOTOUR  = 5'd8,
        V_BAD_SRC    = 5'd9,
        V_FRAGMENT   = 5'd10,
        V_UDP        = 5'd11,
        V_TCP        = 5'd12,
        V_OTHER_PROTO= 5'd13,
        V_ICMP_BAD   = 5'd14,
        V_ICMP_OTHER = 5'd15,
        V_ECHO_REQ   = 5'd16
    } t_verdict;

    // Frame state that the parser hands to the classifier.
    typedef struct packed {
        logic [CNT_W-1:0] byte_count;
        logic [15:0]      ether_type;
        logic [47:0]      eth_source;
        logic [47:0]      arp_fixed;
        logic [47:0]      arp_smac;
        logic [31:0]      sender;
        logic [31:0]      target;
        logic [7:0]       version_ihl;
        logic [15:0]      total_length;
        logic [15:0]      frag_word;
        logic [7:0]       protocol;
        logic [15:0]      header_sum;
        logic [15:0]      payload_sum;
        logic [7:0]       odd_byte;
        logic [7:0]       icmp_kind;
    } t_frame;

    function automatic logic [15:0] csum_add(input logic [15:0] s, input logic [15:0] w);
        logic [16:0] t;
        t = {1'b0, s} + {1'b0, w};
        return t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

// File: hw/rtl/iparp_parser.sv
// Byte parser: keeps header fields and running checksums of one frame.
// Uses iparp_pkg.
module iparp_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output iparp_pkg::t_frame   o_next
);
    iparp_pkg::t_frame r_frm, n_frm;
    logic [15:0] k;
    logic [15:0] p;
    logic [5:0]  hlen;
    logic [15:0] w;

    always_comb begin
        n_frm = r_frm;
        p     = r_frm.byte_count;
        k     = p - 16'd14;
        hlen  = {r_frm.version_ihl[3:0], 2'b00};
        w     = {r_frm.odd_byte, i_byte};
        if (r_frm.byte_count < iparp_pkg::CNT_W'(iparp_pkg::MAX_FRAME)) begin
            n_frm.byte_count = r_frm.byte_count + 1'b1;
            if (p >= 16'd6 && p < 16'd12)
                n_frm.eth_source = {r_frm.eth_source[39:0], i_byte};
            else if (p == 16'd12 || p == 16'd13)
                n_frm.ether_type = {r_frm.ether_type[7:0], i_byte};
            if (p >= 16'd14) begin
                if (r_frm.ether_type == iparp_pkg::ETYPE_ARP) begin
                    if (k < 16'd4 || k == 16'd6 || k == 16'd7)
                        n_frm.arp_fixed = {r_frm.arp_fixed[39:0], i_byte};
                    else if (k >= 16'd8 && k < 16'd14)
                        n_frm.arp_smac = {r_frm.arp_smac[39:0], i_byte};
                    else if (k >= 16'd14 && k < 16'd18)
                        n_frm.sender = {r_frm.sender[23:0], i_byte};
                    else if (k >= 16'd24 && k < 16'd28)
                        n_frm.target = {r_frm.target[23:0], i_byte};
                end else if (r_frm.ether_type == iparp_pkg::ETYPE_IPV4) begin
                    if (k == 16'd0) n_frm.version_ihl = i_byte;
                    else if (k == 16'd2 || k == 16'd3)
                        n_frm.total_length = {r_frm.total_length[7:0], i_byte};
                    else if (k == 16'd6 || k == 16'd7)
                        n_frm.frag_word = {r_frm.frag_word[7:0], i_byte};
                    else if (k == 16'd9) n_frm.protocol = i_byte;
                    else if (k >= 16'd12 && k < 16'd16)
                        n_frm.sender = {r_frm.sender[23:0], i_byte};
                    else if (k >= 16'd16 && k < 16'd20)
                        n_frm.target = {r_frm.target[23:0], i_byte};
                    if (k == {10'd0, hlen}) n_frm.icmp_kind = i_byte;
                    if (!k[0]) begin
                        n_frm.odd_byte = i_byte;
                    end else if (k < {10'd0, hlen}) begin
                        n_frm.header_sum = iparp_pkg::csum_add(r_frm.header_sum, w);
                    end else begin
                        n_frm.payload_sum = iparp_pkg::csum_add(r_frm.payload_sum, w);
                    end
                end
            end
        end
    end

    assign o_next = n_frm;

    // Clear per-frame state after the last beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frm <= '0;
        end else if (i_take) begin
            r_frm <= i_last ? '0 : n_frm;
        end
    end
endmodule

// File: hw/rtl/iparp_classify.sv
// Verdict logic on the completed frame state; purely combinational.
// Uses iparp_pkg.
module iparp_classify (
    input  iparp_pkg::t_frame   i_frm,
    input  logic [31:0]         i_local_ip,
    input  logic [31:0]         i_subnet_mask,
    output logic [4:0]          o_verdict,
    output logic [31:0]         o_peer_ip,
    output logic [47:0]         o_peer_mac
);
    logic [15:0] plen;
    logic [15:0] hlen;
    logic        bcast;
    logic [15:0] s;
    iparp_pkg::t_verdict v;

    always_comb begin
        plen = i_frm.byte_count - 16'd14;
        hlen = {10'd0, i_frm.version_ihl[3:0], 2'b00};
        if (i_frm.target == 32'hffffffff) bcast = 1'b1;
        else if (i_frm.target == i_local_ip) bcast = 1'b0;
        else bcast = ((i_frm.target & i_subnet_mask) == (i_local_ip & i_subnet_mask))
                  && ((i_frm.target & ~i_subnet_mask) == ~i_subnet_mask);
        s = i_frm.payload_sum;
        if (plen[0]) s = iparp_pkg::csum_add(s, {i_frm.odd_byte, 8'd0});
        o_peer_ip  = '0;
        o_peer_mac = '0;
        if (i_frm.byte_count <= 16'd14) begin
            v = iparp_pkg::V_SHORT;
        end else begin
            o_peer_mac = i_frm.eth_source;
            if (i_frm.ether_type == iparp_pkg::ETYPE_ARP) begin
                if (plen < 16'd28 || i_frm.arp_fixed[47:32] != 16'd1
                    || i_frm.arp_fixed[31:16] != iparp_pkg::ETYPE_IPV4) begin
                    v = iparp_pkg::V_ARP_BAD;
                end else begin
                    o_peer_ip  = i_frm.sender;
                    o_peer_mac = i_frm.arp_smac;
                    if (i_frm.target != i_local_ip) v = iparp_pkg::V_ARP_NOTOUR;
                    else if (i_frm.arp_fixed[15:0] == 16'd1) v = iparp_pkg::V_ARP_REQ;
                    else v = iparp_pkg::V_ARP_LEARN;
                end
            end else if (i_frm.ether_type != iparp_pkg::ETYPE_IPV4) begin
                v = iparp_pkg::V_OTHER_ETH;
            end else if (plen < 16'd20 || i_frm.version_ihl[7:4] != iparp_pkg::IP_VERSION
                         || hlen < 16'd20 || hlen > plen || i_frm.total_length > plen) begin
                v = iparp_pkg::V_IP_INVALID;
            end else begin
                o_peer_ip = i_frm.sender;
                if (i_frm.header_sum != iparp_pkg::SUM_OK) v = iparp_pkg::V_IP_CSUM;
                else if (!bcast && i_frm.target != i_local_ip) v = iparp_pkg::V_IP_NOTOUR;
                else if (i_frm.sender == 32'hffffffff || i_frm.sender[31:28] == 4'he)
                    v = iparp_pkg::V_BAD_SRC;
                else if (i_frm.frag_word[13:0] != 14'd0) v = iparp_pkg::V_FRAGMENT;
                else if (i_frm.protocol == iparp_pkg::PROTO_UDP) v = iparp_pkg::V_UDP;
                else if (i_frm.protocol == iparp_pkg::PROTO_TCP) v = iparp_pkg::V_TCP;
                else if (i_frm.protocol != iparp_pkg::PROTO_ICMP) v = iparp_pkg::V_OTHER_PROTO;
                else if (plen - hlen < 16'd4 || s != iparp_pkg::SUM_OK)
                    v = iparp_pkg::V_ICMP_BAD;
                else if (i_frm.icmp_kind == iparp_pkg::ICMP_ECHO) v = iparp_pkg::V_ECHO_REQ;
                else v = iparp_pkg::V_ICMP_OTHER;
            end
        end
        o_verdict = v;
    end
endmodule

// File: hw/rtl/ipv4_arp_icmp_rx_classifier_top.sv
// IPv4/ARP/ICMP receive classifier, top level.
// After the last beat is taken, the verdict goes through frame state reg then result reg.
// One byte per cycle unless output stalls; set by the single-pass parser register.
// Reset (synchronous, active low): clears frame state, empties the pipeline,
// loads local_ip 10.1.23.2 and subnet_mask 255.255.255.0.
module ipv4_arp_icmp_rx_classifier_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // frame_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata    // [4:0] verdict, [36:5] peer_ip, [84:37] peer_mac
);
    logic [31:0] r_local_ip, r_mask;
    iparp_pkg::t_frame w_next, r_done;
    logic        r_done_v;
    logic [4:0]  w_verdict;
    logic [31:0] w_pip;
    logic [47:0] w_pmac;
    logic        r_out_v;
    logic [84:0] r_out;
    logic        take, adv;

    assign adv           = !r_out_v || m_axis_tready;
    assign s_axis_tready = adv || !r_done_v;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip <= 32'd167843586;
            r_mask     <= 32'hffffff00;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                iparp_pkg::REG_LOCAL_IP: r_local_ip <= i_cfg_data;
                iparp_pkg::REG_MASK:     r_mask     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    iparp_parser u_parser (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take),
        .i_byte(s_axis_tdata), .i_last(s_axis_tlast), .o_next(w_next)
    );

    // Hold the finished frame state one stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done_v <= 1'b0;
        end else if (adv || !r_done_v) begin
            r_done_v <= take && s_axis_tlast;
        end
    end
    always_ff @(posedge i_clk) begin
        if ((adv || !r_done_v) && take && s_axis_tlast) r_done <= w_next;
    end

    iparp_classify u_cls (
        .i_frm(r_done), .i_local_ip(r_local_ip), .i_subnet_mask(r_mask),
        .o_verdict(w_verdict), .o_peer_ip(w_pip), .o_peer_mac(w_pmac)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= r_done_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv && r_done_v) r_out <= {w_pmac, w_pip, w_verdict};
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {3'd0, r_out};
endmodule

// File: hw/rtl/iparp_checker.sv
// Port-level checker for the classifier, bound to the top level.
// Uses iparp_pkg.
module iparp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[4:0] <= 5'(iparp_pkg::V_ECHO_REQ))
        else $error("verdict out of range");
    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[4:0] == 5'(iparp_pkg::V_SHORT)
        |-> m_axis_tdata[84:5] == '0)
        else $error("short frame with peer data");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output empty");
endmodule

bind ipv4_arp_icmp_rx_classifier_top iparp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

// File: test/tb_top.sv
// Self-checking testbench for the IPv4/ARP/ICMP receive classifier.
// Builds Ethernet frames, predicts one verdict per frame, checks each result beat.
// Depends on iparp_pkg and ipv4_arp_icmp_rx_classifier_top.
`timescale 1ns / 1ps

module tb_top;
    import iparp_pkg::*;

    localparam int         CYCLE_LIMIT     = 600000;
    localparam int         HOLD_CYCLES     = 400;

    typedef struct {
        logic [7:0] d;
        logic       last;
    } t_beat;

    typedef struct {
        t_verdict    v;
        logic [31:0] ip;
        logic [47:0] mac;
    } t_expect;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;

    ipv4_arp_icmp_rx_classifier_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    t_beat       beats_q[$];
    t_expect     verdicts_q[$];
    logic [7:0]  fb[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          cycle_cnt = 0;
    bit          hold_arm = 0;
    bit          hold_spent = 0;
    int          hold_left = 0;
    logic [31:0] cur_ip = 32'h0A01_1702;
    logic [31:0] cur_mask = 32'hFFFF_FF00;

    // Predictor copy of the per-frame state
    logic [15:0] f_cnt = '0, f_etype = '0, f_tlen = '0, f_frag = '0, f_hsum = '0, f_psum = '0;
    logic [47:0] f_src_mac = '0, f_arp_fix = '0, f_arp_mac = '0;
    logic [31:0] f_sip = '0, f_tip = '0;
    logic [7:0]  f_vihl = '0, f_proto = '0, f_odd = '0, f_itype = '0;

    function automatic logic [15:0] fold_add(input logic [15:0] s, input logic [15:0] w);
        logic [16:0] t;
        t = {1'b0, s} + {1'b0, w};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    function automatic bit is_broadcast(input logic [31:0] a);
        if (a == 32'hFFFF_FFFF) return 1;
        if (a == cur_ip) return 0;
        return ((a & cur_mask) == (cur_ip & cur_mask)) && ((a & ~cur_mask) == ~cur_mask);
    endfunction

    function automatic t_expect classify_frame();
        t_expect     r;
        int          len, plen, hlen;
        logic [15:0] s;
        len = f_cnt;
        r.v = V_SHORT; r.ip = '0; r.mac = '0;
        if (len <= 14) return r;
        r.mac = f_src_mac;
        plen = len - 14;
        if (f_etype == ETYPE_ARP) begin
            r.v = V_ARP_BAD;
            if (plen < 28) return r;
            if (f_arp_fix[47:32] != 16'd1 || f_arp_fix[31:16] != ETYPE_IPV4) return r;
            r.ip = f_sip; r.mac = f_arp_mac;
            if (f_tip != cur_ip) r.v = V_ARP_NOTOUR;
            else r.v = (f_arp_fix[15:0] == 16'd1) ? V_ARP_REQ : V_ARP_LEARN;
            return r;
        end
        r.v = V_OTHER_ETH;
        if (f_etype != ETYPE_IPV4) return r;
        r.v = V_IP_INVALID;
        hlen = f_vihl[3:0] * 4;
        if (plen < 20 || f_vihl[7:4] != IP_VERSION) return r;
        if (hlen < 20 || hlen > plen || f_tlen > plen) return r;
        r.ip = f_sip;
        if (f_hsum != SUM_OK) r.v = V_IP_CSUM;
        else if (!is_broadcast(f_tip) && f_tip != cur_ip) r.v = V_IP_NOTOUR;
        else if (f_sip == 32'hFFFF_FFFF || f_sip[31:28] == 4'hE) r.v = V_BAD_SRC;
        else if (f_frag[13:0] != 0) r.v = V_FRAGMENT;
        else if (f_proto == PROTO_UDP) r.v = V_UDP;
        else if (f_proto == PROTO_TCP) r.v = V_TCP;
        else if (f_proto != PROTO_ICMP) r.v = V_OTHER_PROTO;
        else if (plen - hlen < 4) r.v = V_ICMP_BAD;
        else begin
            s = f_psum;
            if (plen % 2) s = fold_add(s, {f_odd, 8'h00});
            r.v = (s != SUM_OK) ? V_ICMP_BAD : (f_itype == ICMP_ECHO) ? V_ECHO_REQ : V_ICMP_OTHER;
        end
        return r;
    endfunction

    task automatic track_beat(input logic [7:0] b, input logic last);
        int p, k, hlen;
        if (f_cnt < MAX_FRAME) begin
            p = f_cnt;
            if (p >= 6 && p < 12) f_src_mac = {f_src_mac[39:0], b};
            else if (p == 12 || p == 13) f_etype = {f_etype[7:0], b};
            if (p >= 14) begin
                k = p - 14;
                if (f_etype == ETYPE_ARP) begin
                    if (k < 4 || k == 6 || k == 7) f_arp_fix = {f_arp_fix[39:0], b};
                    else if (k >= 8 && k < 14) f_arp_mac = {f_arp_mac[39:0], b};
                    else if (k >= 14 && k < 18) f_sip = {f_sip[23:0], b};
                    else if (k >= 24 && k < 28) f_tip = {f_tip[23:0], b};
                end else if (f_etype == ETYPE_IPV4) begin
                    if (k == 0) f_vihl = b;
                    else if (k == 2 || k == 3) f_tlen = {f_tlen[7:0], b};
                    else if (k == 6 || k == 7) f_frag = {f_frag[7:0], b};
                    else if (k == 9) f_proto = b;
                    else if (k >= 12 && k < 16) f_sip = {f_sip[23:0], b};
                    else if (k >= 16 && k < 20) f_tip = {f_tip[23:0], b};
                    hlen = f_vihl[3:0] * 4;
                    if (k == hlen) f_itype = b;
                    if (k % 2 == 0) f_odd = b;
                    else if (k < hlen) f_hsum = fold_add(f_hsum, {f_odd, b});
                    else f_psum = fold_add(f_psum, {f_odd, b});
                end
            end
            f_cnt = f_cnt + 16'd1;
        end
        if (last) begin
            verdicts_q.push_back(classify_frame());
            f_cnt = '0; f_etype = '0; f_src_mac = '0; f_arp_fix = '0; f_arp_mac = '0;
            f_sip = '0; f_tip = '0; f_vihl = '0; f_tlen = '0; f_frag = '0; f_proto = '0;
            f_hsum = '0; f_psum = '0; f_odd = '0; f_itype = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [47:0] want,
                                   input logic [47:0] got);
        errors++;
        $display("%0t mismatch %s: expected %h got %h", $realtime, what, want, got);
    endtask

    // Driver: offer the next beat when the slot is free, unless a random idle is drawn
    always @(posedge i_clk) begin
        t_beat nb;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) track_beat(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (beats_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nb = beats_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nb.d;
                    s_axis_tlast  <= nb.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result beat with the oldest verdict
    always @(posedge i_clk) begin
        t_expect e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdicts_q.size() == 0) begin
                    report_mismatch("unexpected result", '0, m_axis_tdata[47:0]);
                end else begin
                    e = verdicts_q.pop_front();
                    if (m_axis_tdata[4:0] != e.v)
                        report_mismatch("verdict", 48'(e.v), 48'(m_axis_tdata[4:0]));
                    if (m_axis_tdata[36:5] != e.ip)
                        report_mismatch("peer_ip", 48'(e.ip), 48'(m_axis_tdata[36:5]));
                    if (m_axis_tdata[84:37] != e.mac)
                        report_mismatch("peer_mac", e.mac, m_axis_tdata[84:37]);
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_arm && !hold_spent) begin
            hold_left  <= HOLD_CYCLES;
            hold_spent <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic put_rand(input int n);
        repeat (n) fb.push_back(8'($urandom));
    endtask

    task automatic put16(input logic [15:0] w);
        fb.push_back(w[15:8]); fb.push_back(w[7:0]);
    endtask

    task automatic put32(input logic [31:0] w);
        put16(w[31:16]); put16(w[15:0]);
    endtask

    function automatic logic [15:0] span_sum(input int a, input int b);
        logic [15:0] s;
        s = '0;
        for (int i = a; i < b; i += 2)
            s = fold_add(s, {fb[i], (i + 1 < b) ? fb[i + 1] : 8'h00});
        return s;
    endfunction

    task automatic start_eth(input logic [15:0] etype);
        fb.delete();
        put_rand(12);
        put16(etype);
    endtask

    task automatic build_arp(input logic [15:0] htype, input logic [15:0] ptype,
                             input logic [15:0] oper, input logic [31:0] tip);
        start_eth(ETYPE_ARP);
        put16(htype); put16(ptype); put_rand(2); put16(oper);
        put_rand(16);
        put32(tip);
    endtask

    task automatic build_ip(input logic [3:0] ver, input logic [3:0] ihl,
                            input logic [15:0] frag, input logic [7:0] proto,
                            input logic [31:0] src, input logic [31:0] dst,
                            input int pay, input logic [7:0] itype,
                            input bit bad_hdr, input bit bad_icmp, input int pad);
        int h0, p0, hl;
        logic [15:0] c;
        start_eth(ETYPE_IPV4);
        h0 = fb.size();
        hl = (ihl < 5) ? 20 : ihl * 4;
        fb.push_back({ver, ihl}); put_rand(1);
        put16(16'(hl + pay)); put_rand(2); put16(frag); put_rand(1);
        fb.push_back(proto); put16(16'h0000); put32(src); put32(dst);
        put_rand(hl - 20);
        c = ~span_sum(h0, h0 + hl);
        fb[h0 + 10] = c[15:8] ^ (bad_hdr ? 8'h40 : 8'h00);
        fb[h0 + 11] = c[7:0];
        p0 = fb.size();
        if (pay > 0) begin
            fb.push_back(itype);
            put_rand(pay - 1 + pad);
        end
        // the ICMP sum covers the padding as well
        if (proto == PROTO_ICMP && pay >= 4) begin
            fb[p0 + 2] = 8'h00; fb[p0 + 3] = 8'h00;
            c = ~span_sum(p0, fb.size());
            fb[p0 + 2] = c[15:8];
            fb[p0 + 3] = c[7:0] ^ (bad_icmp ? 8'h01 : 8'h00);
        end
    endtask

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++) beats_q.push_back('{fb[i], i == len - 1});
    endtask

    function automatic logic [31:0] unicast_src();
        logic [31:0] a;
        a = $urandom;
        if (a[31:28] >= 4'hE) a[31] = 1'b0;
        return a;
    endfunction

    task automatic random_frame();
        int          r, pay;
        logic [31:0] src, dst;
        logic [7:0]  proto;
        logic [15:0] frag;
        r = $urandom_range(99);
        if (r < 60) begin
            src = unicast_src();
            case ($urandom_range(19))
                0: src = 32'hFFFF_FFFF;
                1: src = {4'hE, 28'($urandom)};
                default: ;
            endcase
            case ($urandom_range(9))
                0: dst = 32'hFFFF_FFFF;
                1: dst = cur_ip | ~cur_mask;
                2: dst = $urandom;
                default: dst = cur_ip;
            endcase
            frag = ($urandom_range(9) == 0) ? 16'($urandom) :
                   ($urandom_range(1) ? 16'h4000 : 16'h0000);
            case ($urandom_range(5))
                0: proto = PROTO_UDP;
                1: proto = PROTO_TCP;
                2: proto = 8'($urandom);
                default: proto = PROTO_ICMP;
            endcase
            pay = (proto == PROTO_ICMP) ? $urandom_range(40, 4) : $urandom_range(30);
            if ($urandom_range(19) == 0) pay = $urandom_range(3);
            build_ip(($urandom_range(29) == 0) ? 4'($urandom) : IP_VERSION,
                     ($urandom_range(6) == 0) ? 4'($urandom) : 4'd5,
                     frag, proto, src, dst, pay,
                     $urandom_range(1) ? ICMP_ECHO : 8'($urandom),
                     $urandom_range(19) == 0, $urandom_range(9) == 0,
                     ($urandom_range(4) == 0) ? $urandom_range(6) : 0);
        end else if (r < 82) begin
            build_arp(($urandom_range(9) == 0) ? 16'($urandom) : 16'd1,
                      ($urandom_range(9) == 0) ? 16'($urandom) : ETYPE_IPV4,
                      ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2, 1)),
                      ($urandom_range(3) == 0) ? $urandom : cur_ip);
            put_rand(($urandom_range(3) == 0) ? $urandom_range(18) : 0);
        end else if (r < 92) begin
            start_eth(($urandom_range(2) == 0) ? 16'($urandom) :
                      ($urandom_range(1) ? ETYPE_IPV4 : ETYPE_ARP));
            put_rand($urandom_range(50));
        end else begin
            fb.delete();
            put_rand($urandom_range(15, 1));
        end
        // truncate now and then
        send_frame(($urandom_range(9) == 0) ? $urandom_range(fb.size(), 1) : fb.size());
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_LOCAL_IP) cur_ip = val;
        else cur_mask = val;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (beats_q.size() != 0 || s_axis_tvalid || verdicts_q.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic directed_frames();
        logic [31:0] ok_src;
        ok_src = 32'h0A01_1709;
        fb.delete(); put_rand(1); send_frame(1);
        start_eth(16'h86DD); send_frame(14);
        start_eth(16'h86DD); put_rand(1); send_frame(15);
        build_arp(16'd1, ETYPE_IPV4, 16'd1, cur_ip); send_frame(fb.size());
        build_arp(16'd1, ETYPE_IPV4, 16'd2, cur_ip); send_frame(fb.size());
        build_arp(16'd1, ETYPE_IPV4, 16'd1, ~cur_ip); send_frame(fb.size());
        build_arp(16'd6, ETYPE_IPV4, 16'd1, cur_ip); send_frame(fb.size());
        build_arp(16'd1, ETYPE_IPV4, 16'd1, cur_ip); send_frame(14 + 27);
        build_ip(IP_VERSION, 5, 0, PROTO_UDP, ok_src, cur_ip, 8, 0, 0, 0, 0);
        send_frame(fb.size());
        build_ip(IP_VERSION, 5, 16'h4000, PROTO_TCP, ok_src, 32'hFFFF_FFFF, 20, 0, 0, 0, 0);
        send_frame(fb.size());
        build_ip(IP_VERSION, 6, 0, 8'd47, ok_src, cur_ip | ~cur_mask, 4, 0, 0, 0, 0);
        send_frame(fb.size());
        build_ip(IP_VERSION, 5, 0, PROTO_ICMP, ok_src, cur_ip, 12, ICMP_ECHO, 0, 0, 0);
        send_frame(fb.size());
        build_ip(IP_VERSION, 5, 0, PROTO_ICMP, ok_src, cur_ip, 8, 8'd0, 0, 0, 3);
        send_frame(fb.size());
        // odd ICMP length: last byte summed as a high byte
        build_ip(IP_VERSION, 5, 0, PROTO_ICMP, ok_src, cur_ip, 9, ICMP_ECHO, 0, 0, 0);
        send_frame(fb.size());
        build_ip(IP_VERSION, 5, 0, PROTO_ICMP, ok_src, cur_ip, 12, ICMP_ECHO, 0, 1, 0);
        send_frame(fb.size());
        build_ip(IP_VERSION, 5, 0, PROTO_ICMP, ok_src, cur_ip, 2, ICMP_ECHO, 0, 0, 0);
        send_frame(fb.size());
        build_ip(IP_VERSION, 5, 0, PROTO_UDP, ok_src, cur_ip, 4, 0, 1, 0, 0);
        send_frame(fb.size());
        build_ip(IP_VERSION, 5, 0, PROTO_UDP, ok_src, ~cur_ip, 4, 0, 0, 0, 0);
        send_frame(fb.size());
        build_ip(IP_VERSION, 5, 0, PROTO_UDP, 32'hE000_0001, cur_ip, 4, 0, 0, 0, 0);
        send_frame(fb.size());
        build_ip(IP_VERSION, 5, 0, PROTO_UDP, 32'hFFFF_FFFF, cur_ip, 4, 0, 0, 0, 0);
        send_frame(fb.size());
        build_ip(IP_VERSION, 5, 16'h2000, PROTO_UDP, ok_src, cur_ip, 4, 0, 0, 0, 0);
        send_frame(fb.size());
        build_ip(4'd6, 5, 0, PROTO_UDP, ok_src, cur_ip, 4, 0, 0, 0, 0);
        send_frame(fb.size());
        build_ip(IP_VERSION, 4, 0, PROTO_UDP, ok_src, cur_ip, 4, 0, 0, 0, 0);
        send_frame(fb.size());
        // header longer than the bytes present, and total length beyond the frame
        build_ip(IP_VERSION, 15, 0, PROTO_UDP, ok_src, cur_ip, 0, 0, 0, 0, 0);
        send_frame(14 + 40);
        build_ip(IP_VERSION, 5, 0, PROTO_UDP, ok_src, cur_ip, 6, 0, 0, 0, 0);
        send_frame(fb.size() - 1);
    endtask

    initial begin
        int          sent;
        int          n_frames;
        logic [31:0] ip_set[5];
        logic [31:0] mask_set[5];
        int          idle_set[5];
        int          stall_set[5];
        ip_set    = '{32'h0A01_1702, 32'h0000_0000, 32'hFFFF_FFFF, 32'hC0A8_0A05, 32'h0A01_1702};
        mask_set  = '{32'hFFFF_FF00, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'hFFFF_FFF0};
        idle_set  = '{0, 63, 0, 10, 0};
        stall_set = '{0, 0, 63, 10, 0};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_frames();
        wait_idle();
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_LOCAL_IP, ip_set[ph]);
            write_reg(REG_MASK, mask_set[ph]);
            send_idle_pct  = idle_set[ph];
            recv_stall_pct = stall_set[ph];
            if (ph == 4) hold_arm = 1;
            sent = 0;
            n_frames = 0;
            // the hold-off phase needs enough frames queued to back up the input
            while (sent < 40 || n_frames < ((ph == 4) ? 4 : 2)) begin
                random_frame();
                sent = beats_q.size() + sent;
                n_frames++;
                while (beats_q.size() > 64) @(posedge i_clk);
            end
            wait_idle();
        end
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
